>>> rtl/bbrc_pkg.sv
package bbrc_pkg;

    localparam int unsigned BLOCK_BYTES = 32;
    localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned CNT_W       = 9;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned EXCESS_W    = 8;
    localparam int unsigned VERDICT_W   = 3;
    localparam int unsigned RUN_SLACK_W = 8;
    localparam int unsigned BAL_SLACK_W = 7;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam int unsigned RUN_BASE    = 29;
    localparam int unsigned BAL_CENTER  = 128;
    localparam int unsigned BAL_MARGIN  = 167 - 128;
    localparam int unsigned BAL_HIGH    = BAL_CENTER + BAL_MARGIN;
    localparam int unsigned BAL_LOW     = BAL_CENTER - BAL_MARGIN;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SLACK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_SLACK = 1'd1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_PASS      = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MANY_ONES = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FEW_ONES  = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_ZERO_RUN  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_ONE_RUN   = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0] ones;
        logic             cur_bit;
        logic [CNT_W-1:0] cur_run;
        logic [CNT_W-1:0] long_zero;
        logic [CNT_W-1:0] long_one;
    } t_stats;

endpackage

>>> rtl/bbrc_in_if.sv
interface bbrc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bbrc_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> rtl/bbrc_out_if.sv
interface bbrc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bbrc_pkg::VERDICT_W-1:0] verdict;
    logic [bbrc_pkg::EXCESS_W-1:0]  excess;

    modport source (output valid, output verdict, output excess, input ready);
    modport sink   (input valid, input verdict, input excess, output ready);
endinterface

>>> rtl/bbrc_byte_update.sv
module bbrc_byte_update (
    input  bbrc_pkg::t_stats                i_stats,
    input  logic [bbrc_pkg::BYTE_W-1:0]     i_byte,
    output bbrc_pkg::t_stats                o_stats
);
    import bbrc_pkg::*;

    // eight bits, lsb first, each one a short run/count step
    always_comb begin
        t_stats s;
        s = i_stats;
        for (int i = 0; i < BYTE_W; i++) begin
            if (s.cur_run != '0 && i_byte[i] == s.cur_bit) begin
                s.cur_run = s.cur_run + CNT_W'(1);
            end else begin
                s.cur_run = CNT_W'(1);
                s.cur_bit = i_byte[i];
            end
            s.ones = s.ones + CNT_W'(i_byte[i]);
            if (i_byte[i]) begin
                if (s.cur_run > s.long_one) s.long_one = s.cur_run;
            end else begin
                if (s.cur_run > s.long_zero) s.long_zero = s.cur_run;
            end
        end
        o_stats = s;
    end

endmodule

>>> rtl/bit_balance_run_checker.sv
// bit balance and run checker: takes a 256-bit block as 32 words of one byte,
// bit 0 of each byte first, and after the 32nd word gives one result word.
// verdict 1 when ones exceed 167 + balance_slack, 2 when ones fall below
// 89 - balance_slack, 3 or 4 when the longest zero or one run exceeds
// 29 + run_slack, first match wins, else 0; excess is the distance past the
// base limit (167, 89 or 29), 0 on pass. runs crossing byte borders count.
// one input word is taken every cycle unless a last byte waits for a free
// final stage: the eight-bit run and popcount update between the input and
// block statistics registers sets that rate. a result waits in the output
// register while the next block streams in. config is written through
// i_cfg_we / i_cfg_idx / i_cfg_data (0 run_slack, 1 balance_slack); the user
// must write it only while the block is idle, not enforced by the block.
module bit_balance_run_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bbrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bbrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bbrc_in_if.sink                          i_in,
    bbrc_out_if.source                       o_out
);
    import bbrc_pkg::*;

    // configuration registers
    logic [RUN_SLACK_W-1:0] r_run_slack;
    logic [BAL_SLACK_W-1:0] r_bal_slack;

    // input stage
    logic              r_a_vld;
    logic [BYTE_W-1:0] r_a_byte;

    // block statistics
    logic [IDX_W-1:0]  r_idx;
    t_stats            r_stats;
    t_stats            n_stats;

    // final statistics of a finished block
    logic              r_fin_vld;
    t_stats            r_fin;

    // output register
    logic                 r_out_vld;
    logic [VERDICT_W-1:0] r_out_verdict;
    logic [EXCESS_W-1:0]  r_out_excess;
    logic [VERDICT_W-1:0] n_verdict;
    logic [EXCESS_W-1:0]  n_excess;

    // flow control
    logic out_free;
    logic fin_adv;
    logic fin_free;
    logic a_last;
    logic a_adv;
    logic a_free;

    assign out_free = !r_out_vld || o_out.ready;
    assign fin_adv  = r_fin_vld && out_free;
    assign fin_free = !r_fin_vld || out_free;
    assign a_last   = (r_idx == IDX_W'(BLOCK_BYTES - 1));
    // only the last byte of a block needs room in the final stage
    assign a_adv    = r_a_vld && (!a_last || fin_free);
    assign a_free   = !r_a_vld || a_adv;

    assign i_in.ready    = a_free;
    assign o_out.valid   = r_out_vld;
    assign o_out.verdict = r_out_verdict;
    assign o_out.excess  = r_out_excess;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_slack <= '0;
            r_bal_slack <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RUN_SLACK: r_run_slack <= i_cfg_data[RUN_SLACK_W-1:0];
                CFG_BAL_SLACK: r_bal_slack <= i_cfg_data[BAL_SLACK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_free) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in.valid) begin
            r_a_byte <= i_in.data_byte;
        end
    end

    // run and popcount update for one byte
    bbrc_byte_update u_update (
        .i_stats (r_stats),
        .i_byte  (r_a_byte),
        .o_stats (n_stats)
    );

    // block statistics, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_stats <= '0;
        end else if (a_adv) begin
            r_idx <= r_idx + IDX_W'(1);
            if (a_last) begin
                r_stats <= '0;
            end else begin
                r_stats <= n_stats;
            end
        end
    end

    // final stage holds one finished block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (a_adv && a_last) begin
            r_fin_vld <= 1'b1;
        end else if (fin_adv) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && a_last) begin
            r_fin <= n_stats;
        end
    end

    // verdict, first test that holds wins
    always_comb begin
        logic [CNT_W-1:0]   hi_lim;
        logic [CNT_W:0]     lo_sum;
        logic [CNT_W-1:0]   run_lim;
        hi_lim  = CNT_W'(BAL_HIGH) + CNT_W'(r_bal_slack);
        lo_sum  = (CNT_W+1)'(r_fin.ones) + (CNT_W+1)'(r_bal_slack);
        run_lim = CNT_W'(RUN_BASE) + CNT_W'(r_run_slack);
        n_verdict = VERDICT_PASS;
        n_excess  = '0;
        priority if (r_fin.ones > hi_lim) begin
            n_verdict = VERDICT_MANY_ONES;
            n_excess  = EXCESS_W'(r_fin.ones - CNT_W'(BAL_HIGH));
        end else if (lo_sum < (CNT_W+1)'(BAL_LOW)) begin
            // ones + slack < 89 stands for ones < 89 - slack, never true
            // once the slack reaches 89
            n_verdict = VERDICT_FEW_ONES;
            n_excess  = EXCESS_W'(CNT_W'(BAL_LOW) - r_fin.ones);
        end else if (r_fin.long_zero > run_lim) begin
            n_verdict = VERDICT_ZERO_RUN;
            n_excess  = EXCESS_W'(r_fin.long_zero - CNT_W'(RUN_BASE));
        end else if (r_fin.long_one > run_lim) begin
            n_verdict = VERDICT_ONE_RUN;
            n_excess  = EXCESS_W'(r_fin.long_one - CNT_W'(RUN_BASE));
        end else begin
            n_verdict = VERDICT_PASS;
            n_excess  = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv) begin
            r_out_verdict <= n_verdict;
            r_out_excess  <= n_excess;
        end
    end

endmodule

>>> rtl/bbrc_checker.sv
module bbrc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [bbrc_pkg::VERDICT_W-1:0]   i_out_verdict,
    input  logic [bbrc_pkg::EXCESS_W-1:0]    i_out_excess
);
    import bbrc_pkg::*;

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_verdict) && $stable(i_out_excess))
        else $error("result word changed while stalled");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // pass carries no excess
    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_verdict == VERDICT_PASS |-> i_out_excess == '0)
        else $error("pass with nonzero excess");

    // a flag is only raised past its base limit
    a_flag_excess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_verdict != VERDICT_PASS |->
            i_out_excess != '0 &&
            (i_out_verdict == VERDICT_MANY_ONES || i_out_verdict == VERDICT_FEW_ONES ||
             i_out_verdict == VERDICT_ZERO_RUN || i_out_verdict == VERDICT_ONE_RUN))
        else $error("flagged result without excess or bad verdict");

    // a balance flag never exceeds the distance to an empty or full block
    a_bal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid &&
            (i_out_verdict == VERDICT_MANY_ONES || i_out_verdict == VERDICT_FEW_ONES) |->
            i_out_excess <= EXCESS_W'(BAL_LOW))
        else $error("balance excess out of range");

endmodule

bind bit_balance_run_checker bbrc_checker u_bbrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_verdict (o_out.verdict),
    .i_out_excess  (o_out.excess)
);
